// ----- hw/rtl/c3af_pkg.sv -----
package c3af_pkg;

    localparam int NUM_TAPS  = 9;
    localparam int COEF_W    = 7;
    localparam int SUM_W     = 20;
    localparam int SUM_MAG_W = 18;
    localparam int CNT_W     = 24;
    localparam int LW_W      = 16;

    localparam logic [12:0] LINE_W_RST  = 13'd640;
    localparam logic [23:0] FRAME_RST   = 24'd307200;
    localparam logic [62:0] COEFS_RST   = 63'd72624976668147841;
    localparam logic [7:0]  DIVISOR_RST = 8'd9;

    typedef enum logic [1:0] {
        REG_LINE_WIDTH   = 2'd0,
        REG_FRAME_PIXELS = 2'd1,
        REG_KERNEL_COEFS = 2'd2,
        REG_DIVISOR      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel_in;
    } t_in;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_end;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_TAP,
        S_DIV,
        S_WRITE,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        TAP_ZERO,
        TAP_MEM,
        TAP_BYPASS
    } t_tap_sel;

    typedef struct packed {
        logic       take;
        logic       prep;
        logic       tap_issue;
        logic [3:0] tap_idx;
        logic       acc_en;
        logic       div_init;
        logic       div_step;
        logic       write;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_ready;
    } t_status;

endpackage

// ----- hw/rtl/c3af_ram.sv -----
module c3af_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8194
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/c3af_ctrl.sv -----
module c3af_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  c3af_pkg::t_status i_status,
    output c3af_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);

    c3af_pkg::t_state r_state, n_state;
    logic [4:0]       r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c3af_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            c3af_pkg::S_IDLE: begin
                // hold off requests while reset is asserted
                if (i_rst_n) begin
                    o_in_stall = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.take = 1'b1;
                        n_state    = c3af_pkg::S_PREP;
                    end
                end
            end
            c3af_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = c3af_pkg::S_CHECK;
            end
            c3af_pkg::S_CHECK: begin
                n_cnt = '0;
                if (i_status.emit) begin
                    n_state = c3af_pkg::S_TAP;
                end else begin
                    n_state = c3af_pkg::S_WRITE;
                end
            end
            c3af_pkg::S_TAP: begin
                // issue tap reads and accumulate each read in the following cycle
                o_cmd.tap_idx   = r_cnt[3:0];
                o_cmd.tap_issue = (r_cnt < 5'(c3af_pkg::NUM_TAPS));
                o_cmd.acc_en    = (r_cnt != '0);
                if (r_cnt == 5'(c3af_pkg::NUM_TAPS)) begin
                    n_cnt   = '0;
                    n_state = c3af_pkg::S_DIV;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            c3af_pkg::S_DIV: begin
                o_cmd.div_init = (r_cnt == '0);
                o_cmd.div_step = (r_cnt != '0);
                if (r_cnt == 5'(c3af_pkg::SUM_MAG_W)) begin
                    n_cnt   = '0;
                    n_state = c3af_pkg::S_WRITE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            c3af_pkg::S_WRITE: begin
                o_cmd.write = 1'b1;
                if (i_status.emit) begin
                    n_state = c3af_pkg::S_OUT;
                end else begin
                    n_state = c3af_pkg::S_IDLE;
                end
            end
            c3af_pkg::S_OUT: begin
                if (i_status.out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = c3af_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = c3af_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/c3af_datapath.sv -----
module c3af_datapath #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [62:0]       i_cfg_data,
    input  c3af_pkg::t_in     i_in_data,
    input  c3af_pkg::t_cmd    i_cmd,
    output c3af_pkg::t_status o_status,
    output logic              o_out_valid,
    output c3af_pkg::t_out    o_out_data,
    input  logic              i_out_stall
);

    localparam int DEPTH = 2 * MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = AW + 2;
    localparam int CW    = c3af_pkg::CNT_W;
    localparam int MW    = c3af_pkg::SUM_MAG_W;

    // configuration
    logic [12:0] r_line_w;
    logic [23:0] r_frame;
    logic [62:0] r_coefs;
    logic [7:0]  r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_w <= c3af_pkg::LINE_W_RST;
            r_frame  <= c3af_pkg::FRAME_RST;
            r_coefs  <= c3af_pkg::COEFS_RST;
            r_div    <= c3af_pkg::DIVISOR_RST;
        end else if (i_cfg_we) begin
            unique case (c3af_pkg::t_reg_idx'(i_cfg_idx))
                c3af_pkg::REG_LINE_WIDTH:   r_line_w <= i_cfg_data[12:0];
                c3af_pkg::REG_FRAME_PIXELS: r_frame  <= i_cfg_data[23:0];
                c3af_pkg::REG_KERNEL_COEFS: r_coefs  <= i_cfg_data;
                c3af_pkg::REG_DIVISOR:      r_div    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [c3af_pkg::LW_W-1:0] w_eff;
    logic [CW-1:0]             frame_eff;
    logic [7:0]                div_eff;

    always_comb begin
        if (r_line_w == '0) begin
            w_eff = 16'd1;
        end else if (16'(r_line_w) > 16'(MAX_WIDTH)) begin
            w_eff = 16'(MAX_WIDTH);
        end else begin
            w_eff = 16'(r_line_w);
        end
        frame_eff = (r_frame == '0) ? 24'd1 : r_frame;
        div_eff   = (r_div == '0) ? 8'd1 : r_div;
    end

    // frame position state
    c3af_pkg::t_in r_item;
    logic [CW-1:0] r_recv, r_emit, r_push_pos;
    logic [AW-1:0] r_wr_ptr, r_e_ptr, r_push_addr;
    logic          r_pushed, r_emit_flag;
    logic [7:0]    r_sample;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        q = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
        return q;
    endfunction

    logic [CW-1:0] rc0, rc1, ec0;
    logic [AW-1:0] wp0, ep0;
    logic [AW:0]   wp_c;
    logic          push, emit;

    always_comb begin
        rc0 = (r_recv > frame_eff) ? frame_eff : r_recv;
        ec0 = r_emit;
        wp0 = r_wr_ptr;
        ep0 = r_e_ptr;
        // a clamped receive count pulls the write pointer back to match
        wp_c = {1'b0, r_e_ptr} + (AW+1)'(frame_eff - r_emit);
        if (r_recv > frame_eff) begin
            wp0 = (wp_c >= (AW+1)'(DEPTH)) ? AW'(wp_c - (AW+1)'(DEPTH)) : wp_c[AW-1:0];
        end
        if (r_emit >= frame_eff) begin
            rc0 = '0;
            ec0 = '0;
            wp0 = '0;
            ep0 = '0;
        end
        push = (rc0 < frame_eff);
        rc1  = push ? rc0 + CW'(1) : rc0;
        emit = ((26'(ec0) + 26'(w_eff) + 26'd2) <= 26'(rc1)) ||
               ((rc1 == frame_eff) && !push);
    end

    // tap addressing
    logic signed [OW-1:0] off, w_s, a_s;
    logic signed [CW+1:0] p_s;
    logic [AW-1:0]        tap_addr;
    c3af_pkg::t_tap_sel   tap_sel;

    always_comb begin
        w_s = signed'(OW'(w_eff));
        unique case (i_cmd.tap_idx)
            4'd0:    off = -w_s - OW'(1);
            4'd1:    off = -w_s;
            4'd2:    off = -w_s + OW'(1);
            4'd3:    off = -OW'(1);
            4'd4:    off = '0;
            4'd5:    off = OW'(1);
            4'd6:    off = w_s - OW'(1);
            4'd7:    off = w_s;
            4'd8:    off = w_s + OW'(1);
            default: off = '0;
        endcase
        p_s = signed'({2'b00, r_emit}) + (CW+2)'(off);
        a_s = signed'({2'b00, r_e_ptr}) + off;
        if (a_s < 0) begin
            a_s = a_s + OW'(DEPTH);
        end else if (a_s >= OW'(DEPTH)) begin
            a_s = a_s - OW'(DEPTH);
        end
        tap_addr = a_s[AW-1:0];
        if (p_s < 0 || p_s >= signed'({2'b00, frame_eff})) begin
            tap_sel = c3af_pkg::TAP_ZERO;
        end else if (r_pushed && p_s == signed'({2'b00, r_push_pos})) begin
            tap_sel = c3af_pkg::TAP_BYPASS;
        end else begin
            tap_sel = c3af_pkg::TAP_MEM;
        end
    end

    logic [7:0] rd_data;

    c3af_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write && r_pushed),
        .i_waddr (r_push_addr),
        .i_wdata (r_sample),
        .i_re    (i_cmd.tap_issue),
        .i_raddr (tap_addr),
        .o_rdata (rd_data)
    );

    // multiply-accumulate
    logic [3:0]                     r_tap_j;
    c3af_pkg::t_tap_sel             r_tap_sel;
    logic signed [c3af_pkg::SUM_W-1:0] r_acc;
    logic [7:0]                     tap_v;
    logic signed [c3af_pkg::COEF_W-1:0] coef;
    logic signed [15:0]             prod;

    always_comb begin
        unique case (r_tap_sel)
            c3af_pkg::TAP_MEM:    tap_v = rd_data;
            c3af_pkg::TAP_BYPASS: tap_v = r_sample;
            default:              tap_v = '0;
        endcase
        coef = signed'(r_coefs[7 * r_tap_j +: c3af_pkg::COEF_W]);
        prod = 16'(coef) * signed'({8'd0, tap_v});
    end

    // divider: restoring, one quotient bit per step on the low sum bits
    logic          r_neg;
    logic [MW-1:0] r_dq;
    logic [7:0]    r_rem;
    logic [8:0]    trial;
    logic          trial_ge;

    always_comb begin
        trial    = {r_rem, r_dq[MW-1]};
        trial_ge = (trial >= {1'b0, div_eff});
    end

    logic [7:0] q_sat;

    always_comb begin
        if (r_neg) begin
            q_sat = '0;
        end else if (r_dq > MW'(255)) begin
            q_sat = 8'd255;
        end else begin
            q_sat = r_dq[7:0];
        end
    end

    logic r_out_valid;
    c3af_pkg::t_out r_out;
    logic [CW-1:0] ec1;

    assign ec1 = r_emit + CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_in_data;
        end
        if (i_cmd.prep) begin
            r_push_pos  <= rc0;
            r_push_addr <= wp0;
            r_sample    <= r_item.mode ? 8'd0 : r_item.pixel_in;
            r_acc       <= '0;
        end
        if (i_cmd.tap_issue) begin
            r_tap_j   <= i_cmd.tap_idx;
            r_tap_sel <= tap_sel;
        end
        if (i_cmd.acc_en) begin
            r_acc <= r_acc + c3af_pkg::SUM_W'(prod);
        end
        if (i_cmd.div_init) begin
            r_neg <= (r_acc < 0);
            r_dq  <= r_acc[MW-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? 8'(trial - {1'b0, div_eff}) : trial[7:0];
            r_dq  <= {r_dq[MW-2:0], trial_ge};
        end
        if (i_cmd.load_out) begin
            r_out.pixel_out <= q_sat;
            r_out.frame_end <= (r_emit == frame_eff - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv      <= '0;
            r_emit      <= '0;
            r_wr_ptr    <= '0;
            r_e_ptr     <= '0;
            r_pushed    <= 1'b0;
            r_emit_flag <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.prep) begin
                r_recv      <= rc1;
                r_emit      <= ec0;
                r_wr_ptr    <= push ? ptr_inc(wp0) : wp0;
                r_e_ptr     <= ep0;
                r_pushed    <= push;
                r_emit_flag <= emit;
            end
            if (i_cmd.load_out) begin
                // restart both counters after the last pixel of the frame
                if (ec1 >= frame_eff) begin
                    r_recv   <= '0;
                    r_emit   <= '0;
                    r_wr_ptr <= '0;
                    r_e_ptr  <= '0;
                end else begin
                    r_emit  <= ec1;
                    r_e_ptr <= ptr_inc(r_e_ptr);
                end
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the divider runs on the raw low sum bits; a negative sum gives zero anyway
    assign o_status.emit      = r_emit_flag;
    assign o_status.out_ready = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule

// ----- hw/rtl/conv3x3_alpha_filter_core.sv -----
// 3x3 convolution over the alpha byte of a raster-order frame.
// Input channel: i_in_valid / o_in_stall carry one request per pixel
// (mode 0 pixel, mode 1 flush padding). Output channel: o_out_valid /
// i_out_stall carry one filtered byte, frame_end marking the frame's last.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 line width, 1 frame pixels, 2 kernel coefficients, 3 divisor).
// Output p appears for the request carrying pixel p+line_width+1; flush
// requests after the frame release the remaining outputs, one each.
// Steps: a request that releases no output passes the prep, check and
// write states; one that releases an output is loaded into the output
// register after tap reads through the single read port of the line
// store, accumulated one read behind, and the bit-serial divider
// (a load, then one quotient bit per cycle), plus control steps.
// One request is in work at a time; the next is taken as soon as the
// result sits in the output register, even while the receiver stalls it.
// A stalled result holds in the output register; a second result waits
// in the controller until that register empties.
// Reset (synchronous, i_rst_n low) restores the register defaults and
// restarts the frame counters; the line store needs no clearing pass.
module conv3x3_alpha_filter_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [62:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  c3af_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output c3af_pkg::t_out o_out_data
);

    c3af_pkg::t_cmd    cmd;
    c3af_pkg::t_status status;

    c3af_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    c3af_datapath #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
